/* src/ukt_pkg.sv */
// Unique key table: shared types and codes.
// Used by the cell row, the controller and the top level.
package ukt_pkg;

    localparam int KEY_W = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_RENAME = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Table update applied by every cell in the same cycle
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_SHIFT  = 2'd2,
        ACT_RENAME = 2'd3
    } act_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_ENC  = 4'b0100,
        S_EXEC = 4'b1000
    } state_t;

    // Broadcast from the controller to the cell row
    typedef struct packed {
        logic             cmp_en;
        act_t             act;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] new_key;
    } cell_bus_t;

endpackage

/* src/ukt_req_if.sv */
// Request channel of the unique key table: valid/ready plus op, key, new_key.
// Depends on nothing.
interface ukt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] new_key;

    modport source (output valid, output op, output key, output new_key, input ready);
    modport sink (input valid, input op, input key, input new_key, output ready);
endinterface

/* src/ukt_rsp_if.sv */
// Result channel of the unique key table: valid/ready plus status, position, count.
// Depends on nothing.
interface ukt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] position;
    logic [8:0] count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink (input valid, input status, input position, input count, output ready);
endinterface

/* src/ukt_cell.sv */
// One table slot: holds a key, compares it against the broadcast keys and
// takes its neighbor's key when a delete closes the gap. Depends on ukt_pkg.
module ukt_cell #(
    parameter int DEPTH = 256,
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  ukt_pkg::cell_bus_t         bus,
    input  logic [$clog2(DEPTH)-1:0]   pos,
    input  logic [$clog2(DEPTH+1)-1:0] count,
    input  logic [ukt_pkg::KEY_W-1:0]  nbr_key,
    output logic [ukt_pkg::KEY_W-1:0]  key_out,
    output logic                       hit_key,
    output logic                       hit_new
);
    import ukt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [KEY_W-1:0] key_reg, key_next;
    logic             hit_key_reg, hit_key_next;
    logic             hit_new_reg, hit_new_next;
    logic             live;
    logic [CNT_W-1:0] pos_ext;

    assign live    = MY_IDX < count;
    assign pos_ext = CNT_W'(pos);

    always_comb
    begin
        key_next     = key_reg;
        hit_key_next = hit_key_reg;
        hit_new_next = hit_new_reg;
        if (bus.cmp_en)
        begin
            hit_key_next = live && (key_reg == bus.key);
            hit_new_next = live && (key_reg == bus.new_key);
        end
        case (bus.act)
            ACT_APPEND: if (MY_IDX == pos_ext) key_next = bus.key;
            ACT_RENAME: if (MY_IDX == pos_ext) key_next = bus.new_key;
            ACT_SHIFT:  if (MY_IDX >= pos_ext) key_next = nbr_key;
            default:    key_next = key_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        hit_key_reg <= hit_key_next;
        hit_new_reg <= hit_new_next;
    end

    assign key_out = key_reg;
    assign hit_key = hit_key_reg;
    assign hit_new = hit_new_reg;
endmodule

/* src/ukt_encoder.sv */
// Turns the row of cell hit flags into a slot index. Keys are unique, so at
// most one flag is set and the index is the OR of the set slots' indexes.
// Depends on nothing.
module ukt_encoder #(
    parameter int DEPTH = 256
) (
    input  logic [DEPTH-1:0]         hits,
    output logic [$clog2(DEPTH)-1:0] idx,
    output logic                     any
);
    localparam int IDX_W = $clog2(DEPTH);

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hits[i])
                idx = idx | IDX_W'(i);
        end
    end

    assign any = |hits;
endmodule

/* src/ukt_ctrl.sv */
// Request sequencer: captures a request, runs compare, encode and execute
// steps over the cell row, and holds the result in an output register.
// Depends on ukt_pkg, ukt_req_if, ukt_rsp_if.
module ukt_ctrl #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ukt_req_if.sink                    req,
    ukt_rsp_if.source                  rsp,
    input  logic [$clog2(DEPTH)-1:0]   key_idx,
    input  logic                       key_any,
    input  logic                       new_any,
    output ukt_pkg::cell_bus_t         bus,
    output logic [$clog2(DEPTH)-1:0]   pos,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import ukt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t           state_reg, state_next;
    op_t              op_reg;
    logic [KEY_W-1:0] key_reg, new_key_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] hit_pos_reg;
    logic             hit_reg, new_hit_reg;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_pos_reg, out_pos_next;
    logic [CNT_W-1:0] out_count_reg;

    act_t             act;
    logic [IDX_W-1:0] act_pos;
    logic             accept, fire;
    logic [IDX_W+7:0] pos_wide;
    logic [CNT_W+8:0] cnt_wide;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    // Decide the outcome from the registered hit information
    always_comb
    begin
        act             = ACT_NONE;
        act_pos         = hit_pos_reg;
        out_status_next = ST_OK;
        out_pos_next    = hit_pos_reg;
        count_next      = count_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (count_reg == FULL_CNT)
                begin
                    out_status_next = ST_FULL;
                    out_pos_next    = '0;
                end
                else if (!hit_reg)
                begin
                    act          = ACT_APPEND;
                    act_pos      = count_reg[IDX_W-1:0];
                    out_pos_next = count_reg[IDX_W-1:0];
                    count_next   = count_reg + CNT_W'(1);
                end
                else
                    out_status_next = ST_DUP;
            end
            OP_DELETE:
            begin
                if (!hit_reg)
                begin
                    out_status_next = ST_MISSING;
                    out_pos_next    = '0;
                end
                else
                begin
                    act        = ACT_SHIFT;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_SEARCH:
            begin
                if (!hit_reg)
                begin
                    out_status_next = ST_MISSING;
                    out_pos_next    = '0;
                end
            end
            OP_RENAME:
            begin
                if (!hit_reg)
                begin
                    out_status_next = ST_MISSING;
                    out_pos_next    = '0;
                end
                else if (new_hit_reg)
                    out_status_next = ST_DUP;
                else
                    act = ACT_RENAME;
            end
            default:
                act = ACT_NONE;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_CMP;
            S_CMP:  state_next = S_ENC;
            S_ENC:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op_t'(req.op);
            key_reg     <= req.key;
            new_key_reg <= req.new_key;
        end
        if (state_reg == S_ENC)
        begin
            hit_pos_reg <= key_idx;
            hit_reg     <= key_any;
            new_hit_reg <= new_any;
        end
        if (fire)
        begin
            out_status_reg <= out_status_next;
            out_pos_reg    <= out_pos_next;
            out_count_reg  <= count_next;
        end
    end

    assign bus.cmp_en  = (state_reg == S_CMP);
    assign bus.act     = fire ? act : ACT_NONE;
    assign bus.key     = key_reg;
    assign bus.new_key = new_key_reg;
    assign pos         = act_pos;
    assign count       = count_reg;

    // Position and count are reported modulo their field widths
    assign pos_wide     = {8'd0, out_pos_reg};
    assign cnt_wide     = {9'd0, out_count_reg};
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.position = pos_wide[7:0];
    assign rsp.count    = cnt_wide[8:0];
endmodule

/* src/unique_key_table_core.sv */
// Unique key table: an ordered, duplicate-free table of 64-bit keys kept in
// a row of compare cells. Each request (insert, delete, search, rename) on the
// req channel returns one result (status, position, count) on the rsp channel.
//
// Both channels are valid/ready; an item moves on a clock edge with both high.
// A request runs through capture, parallel compare in every cell, hit
// encode across the row, then execute; a new request is taken only once the
// previous one has left the execute step, where the result is written into
// the output register.
// A delete closes the gap in one update: every cell at or above the hit takes
// its upper neighbor's key. An insert writes the cell at the current count.
// A new request is accepted while a finished result still waits; the execute
// step holds until the output register is free, so a stalled receiver
// stalls the table after at most one further request.
// Reset (rst_n, asynchronous, active low) empties the table by clearing the
// count; the stored keys are left as they are and are never read before
// they are written.
module unique_key_table_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    ukt_req_if.sink   req,
    ukt_rsp_if.source rsp
);
    import ukt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH+1);

    cell_bus_t        bus;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] cell_key [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_key, hit_new;
    logic [IDX_W-1:0] key_idx;
    logic             key_any, new_any;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] nbr;
        if (i == TABLE_DEPTH-1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_key[i+1];
        end

        ukt_cell #(
            .DEPTH (TABLE_DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .bus     (bus),
            .pos     (pos),
            .count   (count),
            .nbr_key (nbr),
            .key_out (cell_key[i]),
            .hit_key (hit_key[i]),
            .hit_new (hit_new[i])
        );
    end

    ukt_encoder #(.DEPTH(TABLE_DEPTH)) u_enc_key (
        .hits (hit_key),
        .idx  (key_idx),
        .any  (key_any)
    );

    // Only the presence of new_key matters
    assign new_any = |hit_new;

    ukt_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .key_idx (key_idx),
        .key_any (key_any),
        .new_any (new_any),
        .bus     (bus),
        .pos     (pos),
        .count   (count)
    );
endmodule
